>>> rtl/lpd_pkg.sv
// lpd_pkg: shared types and constants for the length-prefix deframer
// no dependencies; imported by every module of the deframer

package lpd_pkg;

	// input opcodes
	localparam logic OP_BYTE  = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	// register reset value and header size
	localparam logic [31:0] MAX_FRAME_RESET = 32'd4096;
	localparam logic [1:0]  HDR_LAST_IDX    = 2'd3;

	// queue between front and back
	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	// word kind decided by the front
	typedef enum logic {
		KIND_BYTE,
		KIND_CLEAR
	} kind_t;

	// classified word carried through the queue
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
	} item_t;

	// parser state in the back
	typedef enum logic [1:0] {
		ST_HEADER,
		ST_PAYLOAD,
		ST_ERROR
	} pstate_t;

	// one result word
	typedef struct packed {
		logic        byte_valid;
		logic [7:0]  payload_byte;
		logic        frame_last;
		logic        error_flag;
	} result_t;

endpackage

>>> rtl/lpd_front.sv
// lpd_front: input register stage that accepts words and classifies them
// depends on lpd_pkg

module lpd_front
	import lpd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic [7:0]  data_byte,
	output logic        push_valid,
	input  logic        push_ready,
	output item_t       push_item
);

	logic  valid_s1;
	item_t item_s1;

	// stage frees up when empty or when its word moves into the queue
	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	// stage valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// classify the opcode and hold the byte
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.kind <= (opcode == OP_CLEAR) ? KIND_CLEAR : KIND_BYTE;
			item_s1.data <= data_byte;
		end
	end

endmodule

>>> rtl/lpd_queue.sv
// lpd_queue: short register queue between the front and the back
// depends on lpd_pkg

module lpd_queue
	import lpd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	output logic  push_ready,
	input  item_t push_item,
	output logic  pop_valid,
	input  logic  pop_ready,
	output item_t pop_item
);

	item_t               mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                push;
	logic                pop;

	assign push_ready = (count_q != QCNT_W'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

>>> rtl/lpd_back.sv
// lpd_back: header parser, payload counter, error flag and result register
// depends on lpd_pkg; holds the max_frame_bytes register

module lpd_back
	import lpd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [31:0]  cfg_data,
	input  logic         pop_valid,
	output logic         pop_ready,
	input  item_t        pop_item,
	output logic         out_valid,
	input  logic         out_ready,
	output result_t      result
);

	pstate_t      st_q;
	pstate_t      st_d;
	logic [1:0]   hdr_cnt_q;
	logic [23:0]  len_q;
	logic [31:0]  rem_q;
	logic [31:0]  max_q;
	logic         out_valid_q;
	result_t      res_q;
	result_t      res_d;
	logic         advance;
	logic         is_clear;
	logic         hdr_done;
	logic [31:0]  full_len;
	logic         bad_len;
	logic         rem_last;

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign result    = res_q;

	// take a word when the result register is free or being drained
	assign pop_ready = !out_valid_q || out_ready;
	assign advance   = pop_valid && pop_ready;
	assign is_clear  = (pop_item.kind == KIND_CLEAR);

	// header completion and length check
	assign hdr_done = (hdr_cnt_q == HDR_LAST_IDX);
	assign full_len = {pop_item.data, len_q};
	assign bad_len  = (full_len == '0) || (full_len > max_q);
	assign rem_last = (rem_q == 32'd1);

	// next state
	always_comb begin
		st_d = st_q;
		if (advance) begin
			if (is_clear) begin
				st_d = ST_HEADER;
			end else begin
				unique case (st_q)
					ST_HEADER: begin
						if (hdr_done) begin
							st_d = bad_len ? ST_ERROR : ST_PAYLOAD;
						end
					end
					ST_PAYLOAD: begin
						if (rem_last) begin
							st_d = ST_HEADER;
						end
					end
					ST_ERROR: st_d = ST_ERROR;
					default:  st_d = ST_HEADER;
				endcase
			end
		end
	end

	// result word
	always_comb begin
		res_d = '0;
		if (!is_clear) begin
			unique case (st_q)
				ST_HEADER: begin
					res_d.error_flag = hdr_done && bad_len;
				end
				ST_PAYLOAD: begin
					res_d.byte_valid   = 1'b1;
					res_d.payload_byte = pop_item.data;
					res_d.frame_last   = rem_last;
				end
				ST_ERROR: res_d.error_flag = 1'b1;
				default:  res_d = '0;
			endcase
		end
	end

	// parser registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_HEADER;
			hdr_cnt_q <= '0;
			len_q     <= '0;
			rem_q     <= '0;
		end else if (advance) begin
			st_q <= st_d;
			if (is_clear) begin
				hdr_cnt_q <= '0;
				len_q     <= '0;
				rem_q     <= '0;
			end else if (st_q == ST_HEADER) begin
				hdr_cnt_q <= hdr_cnt_q + 1'b1;
				// little-endian byte placement, upper byte joins at completion
				unique case (hdr_cnt_q)
					2'd0:    len_q[7:0]   <= pop_item.data;
					2'd1:    len_q[15:8]  <= pop_item.data;
					2'd2:    len_q[23:16] <= pop_item.data;
					default: len_q        <= '0;
				endcase
				if (hdr_done && !bad_len) begin
					rem_q <= full_len;
				end
			end else if (st_q == ST_PAYLOAD) begin
				rem_q <= rem_q - 32'd1;
			end
		end
	end

	// max frame length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_FRAME_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_q <= cfg_data;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop_ready) begin
			out_valid_q <= pop_valid;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

endmodule

>>> rtl/length_prefix_deframer.sv
// Length-prefix deframer: each word is a stream byte or a clear command. Four
// header bytes give a little-endian 32-bit payload length; the following
// bytes come out one result word each, the final one flagged frame_last. A
// zero length or one above max_frame_bytes raises error_flag on that word and
// on every later byte until a clear. Every accepted word yields exactly one
// result word. Throughput is one word per cycle while out_ready keeps the
// result register draining; a word passes through the input stage, the queue
// and the result register before its result word is presented.
// max_frame_bytes resets to 4096 and is written through the cfg channel.
// depends on lpd_pkg, lpd_front, lpd_queue, lpd_back

module length_prefix_deframer
	import lpd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [31:0]  cfg_data,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic         opcode,
	input  logic [7:0]   data_byte,
	output logic         out_valid,
	input  logic         out_ready,
	output logic         byte_valid,
	output logic [7:0]   payload_byte,
	output logic         frame_last,
	output logic         error_flag
);

	logic    push_valid;
	logic    push_ready;
	item_t   push_item;
	logic    pop_valid;
	logic    pop_ready;
	item_t   pop_item;
	result_t result;

	// accept and classify
	lpd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.data_byte  (data_byte),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	// decoupling queue
	lpd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	// parse and emit
	lpd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result    (result)
	);

	assign byte_valid   = result.byte_valid;
	assign payload_byte = result.payload_byte;
	assign frame_last   = result.frame_last;
	assign error_flag   = result.error_flag;

endmodule

>>> verif/length_prefix_deframer_test.sv
// length_prefix_deframer_test: self-checking bench for the length-prefix deframer
// drives bytes, clears and max_frame_bytes writes, and predicts every result word
// depends on lpd_pkg and length_prefix_deframer

module length_prefix_deframer_test;
	import lpd_pkg::*;

	localparam int unsigned MAX_GAP     = 17;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned STALL_LIMIT = 3000;
	localparam int unsigned SETTLE      = 8;
	localparam int unsigned PHASE_WORDS = 150;
	localparam int unsigned NUM_PHASES  = 8;

	// frame parser prediction and result checking
	class deframe_scoreboard;
		logic [31:0] max_len;
		logic [1:0]  hdr_cnt;
		logic [31:0] len_acc;
		bit          in_pay;
		logic [31:0] remain;
		bit          err_st;
		result_t     expq[$];
		int unsigned mismatches;
		int unsigned words_in;
		int unsigned results_seen;
		int unsigned frames_done;
		int unsigned error_words;

		function new();
			max_len = MAX_FRAME_RESET;
			clear_state();
		endfunction

		function void clear_state();
			hdr_cnt = '0;
			len_acc = '0;
			in_pay  = 1'b0;
			remain  = '0;
			err_st  = 1'b0;
		endfunction

		function void set_max(logic [31:0] v);
			max_len = v;
		endfunction

		function int pending();
			return expq.size();
		endfunction

		// one accepted word gives one expected result word
		function void note_word(logic op, logic [7:0] b);
			result_t     r;
			logic [31:0] len;
			r = '0;
			if (op == OP_CLEAR) begin
				clear_state();
			end else if (err_st) begin
				r.error_flag = 1'b1;
			end else if (in_pay) begin
				r.byte_valid   = 1'b1;
				r.payload_byte = b;
				remain = remain - 32'd1;
				if (remain == 32'd0) begin
					r.frame_last = 1'b1;
					in_pay = 1'b0;
				end
			end else begin
				// little-endian header assembly
				len_acc = len_acc | (32'(b) << (8 * hdr_cnt));
				if (hdr_cnt == HDR_LAST_IDX) begin
					len = len_acc;
					hdr_cnt = '0;
					len_acc = '0;
					if (len == 32'd0 || len > max_len) begin
						err_st = 1'b1;
						r.error_flag = 1'b1;
					end else begin
						in_pay = 1'b1;
						remain = len;
					end
				end else begin
					hdr_cnt = hdr_cnt + 2'd1;
				end
			end
			expq.insert(expq.size(), r);
			words_in++;
		endfunction

		function void report_bad(string why, result_t want, result_t got);
			mismatches++;
			if (mismatches <= 10)
				$display("%0s: expected v=%0b b=%02h l=%0b e=%0b, got v=%0b b=%02h l=%0b e=%0b",
					why, want.byte_valid, want.payload_byte, want.frame_last,
					want.error_flag, got.byte_valid, got.payload_byte, got.frame_last,
					got.error_flag);
		endfunction

		// compare against the oldest expected word
		function void check_word(result_t got);
			result_t want;
			results_seen++;
			if (got.frame_last === 1'b1)
				frames_done++;
			if (got.error_flag === 1'b1)
				error_words++;
			if (expq.size() == 0) begin
				report_bad("result word with nothing expected", '0, got);
				return;
			end
			want = expq.pop_front();
			if (got.byte_valid !== want.byte_valid ||
				got.payload_byte !== want.payload_byte ||
				got.frame_last !== want.frame_last || got.error_flag !== want.error_flag)
				report_bad("result word mismatch", want, got);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic        opcode;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_ready;
	logic        byte_valid;
	logic [7:0]  payload_byte;
	logic        frame_last;
	logic        error_flag;

	deframe_scoreboard sb;
	bit          tx_idle;
	bit          rx_idle;
	bit          hold_req;
	int unsigned settings_used;
	int unsigned stall_cnt;

	length_prefix_deframer i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.data_byte    (data_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.byte_valid   (byte_valid),
		.payload_byte (payload_byte),
		.frame_last   (frame_last),
		.error_flag   (error_flag)
	);

	// clock, period 12
	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// sample handshakes at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_word(opcode, data_byte);
			if (out_valid && out_ready)
				sb.check_word(result_t'({byte_valid, payload_byte, frame_last, error_flag}));
		end
	end

	// watchdog on cycles without any accepted word
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			stall_cnt <= 0;
		end else if (stall_cnt >= STALL_LIMIT) begin
			$display("watchdog: no word accepted for %0d cycles", STALL_LIMIT);
			$display("Verification failed");
			$finish;
		end else begin
			stall_cnt <= stall_cnt + 1;
		end
	end

	// result side: random ready gaps, one long hold-off on request
	initial begin
		int unsigned w;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			w = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
			if (w > 0) begin
				out_ready <= 1'b0;
				repeat (w) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// offer one word and wait for it to be taken
	task automatic send_word(logic op, logic [7:0] b);
		int unsigned gap;
		gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		opcode    <= op;
		data_byte <= b;
		in_valid  <= 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic send_byte(logic [7:0] b);
		send_word(OP_BYTE, b);
	endtask

	task automatic send_clear();
		send_word(OP_CLEAR, 8'($urandom));
	endtask

	task automatic send_header(logic [31:0] len);
		for (int i = 0; i < 4; i++)
			send_byte(len[8*i +: 8]);
	endtask

	// stop offering and wait for every expected word, plus pipeline slack
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_max(logic [31:0] v);
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.set_max(v);
		settings_used++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// header length mix: mostly short legal frames, plus the boundaries
	function automatic logic [31:0] pick_len(logic [31:0] lim);
		int unsigned sel;
		logic [31:0] cap;
		sel = $urandom_range(0, 15);
		cap = (lim < 32'd20) ? lim : 32'd20;
		case (sel)
			0: return 32'd0;
			1: return (lim == 32'hFFFF_FFFF) ? 32'd0 : lim + 32'd1;
			2: return $urandom;
			3: return lim;
			default: return (cap == 32'd0) ? 32'd1 : $urandom_range(1, cap);
		endcase
	endfunction

	// one frame attempt: short legal frames mostly run to the end; illegal, long or randomly cut ones end in a clear
	task automatic run_frame(logic [31:0] lim);
		logic [31:0] len;
		int unsigned cut;
		len = pick_len(lim);
		send_header(len);
		if (len == 32'd0 || len > lim) begin
			repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
			send_clear();
		end else if (len > 32'd64) begin
			repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
			send_clear();
		end else if ($urandom_range(0, 19) == 0) begin
			cut = $urandom_range(0, len - 1);
			repeat (cut) send_byte(8'($urandom));
			send_clear();
		end else begin
			repeat (len) send_byte(8'($urandom));
		end
	endtask

	// main sequence
	initial begin
		logic [31:0] limits[NUM_PHASES];
		int unsigned start;
		bit          pressed;
		sb = new();
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		in_valid  = 1'b0;
		opcode    = OP_BYTE;
		data_byte = '0;
		tx_idle   = 1'b0;
		rx_idle   = 1'b0;
		hold_req  = 1'b0;
		stall_cnt = 0;
		settings_used = 0;
		pressed   = 1'b0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// directed words under the reset limit
		send_clear();
		send_header(32'd1);
		send_byte(8'hFF);
		// zero length, then a byte while in error
		send_header(32'd0);
		send_byte(8'h00);
		send_clear();
		send_header(32'd2);
		send_byte(8'h80);
		send_byte(8'h7F);
		// one above the limit
		send_header(MAX_FRAME_RESET + 32'd1);
		send_clear();
		// clear in the middle of a header
		send_byte(8'h03);
		send_clear();

		limits[0] = MAX_FRAME_RESET;
		limits[1] = 32'd1;
		limits[2] = 32'd0;
		limits[3] = 32'hFFFF_FFFF;
		limits[4] = $urandom_range(1, 30);
		limits[5] = 32'd2;
		limits[6] = $urandom;
		limits[7] = MAX_FRAME_RESET;

		// random phases, one limit each
		for (int p = 0; p < NUM_PHASES; p++) begin
			drain();
			write_max(limits[p]);
			tx_idle = (p % 4 == 1) || (p % 4 == 2);
			rx_idle = (p % 4 == 1) || (p % 4 == 3);
			start = sb.words_in;
			while (sb.words_in < start + PHASE_WORDS) begin
				if (p == 4 && !pressed && sb.words_in >= start + 60) begin
					hold_req = 1'b1;
					pressed = 1'b1;
				end
				if ($urandom_range(0, 11) == 0) begin
					// noise: stray words of any kind, then a clear
					repeat ($urandom_range(1, 4))
						send_word(1'($urandom_range(0, 1)), 8'($urandom));
					send_clear();
				end else begin
					run_frame(limits[p]);
				end
			end
		end

		drain();
		$display("%0d words sent under %0d length limits, %0d result words checked",
			sb.words_in, settings_used, sb.results_seen);
		$display("%0d frames completed, %0d words flagged in error, %0d mismatches",
			sb.frames_done, sb.error_words, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
